[design/srt_pkg.sv]
// Package with the constants and word types of the segment reassembly tracker.
package srt_pkg;

	localparam int SEG_SLOTS    = 64;
	localparam int SEG_INDEX_W  = $clog2(SEG_SLOTS);
	localparam int SEEN_W       = $clog2(SEG_SLOTS + 1);
	localparam int SEG_BYTES_W  = 13;
	localparam int TOTAL_W      = 19;

	typedef struct packed {
		logic                   clear;
		logic [SEG_INDEX_W-1:0] seg_index;
		logic [SEG_BYTES_W-1:0] seg_bytes;
		logic                   is_last;
	} item_t;

	typedef struct packed {
		logic               complete;
		logic [TOTAL_W-1:0] total_bytes;
		logic               last_seen;
	} result_t;

endpackage

[design/srt_gap_check.sv]
// Gap check over the presence bitmap up to the highest index seen.
module srt_gap_check import srt_pkg::*; (
	input  logic [SEG_SLOTS-1:0] map,
	input  logic [SEEN_W-1:0]    seen,
	output logic                 no_gaps
);

	logic [SEG_SLOTS-1:0] need;

	always_comb begin
		for (int i = 0; i < SEG_SLOTS; i++) begin
			need[i] = (SEEN_W'(i) < seen);
		end
		no_gaps = (seen != '0) && ((map & need) == need);
	end

endmodule

[design/segment_reassembly_tracker.sv]
// Top level of the segment reassembly tracker.
// An accepted word is registered in the input stage (valid_s1, item_s1), and its result is
// then registered into result_q together with the strobe result_valid.
// Throughput: one word every cycle; busy stays low and results cannot be stalled.
// Reset: arst_n clears the input valid flag, the strobe and all tracking state at once.
module segment_reassembly_tracker import srt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    result_valid,
	output result_t result
);

	logic                    valid_s1;
	item_t                   item_s1;

	logic [SEG_SLOTS-1:0]    map_q, map_nxt;
	logic [SEEN_W-1:0]       seen_q, seen_nxt, idx_p1;
	logic [SEG_INDEX_W-1:0]  final_index_q, final_index_nxt;
	logic [SEG_BYTES_W-1:0]  final_bytes_q, final_bytes_nxt;
	logic                    final_known_q, final_known_nxt;
	logic [SEG_BYTES_W-1:0]  common_bytes_q, common_bytes_nxt;
	logic                    common_known_q, common_known_nxt;
	logic                    done_q, done_nxt;
	logic                    no_gaps;
	logic [SEG_BYTES_W-1:0]  common_eff;
	logic [TOTAL_W-1:0]      total;
	logic                    result_valid_q;
	result_t                 result_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		map_nxt          = map_q | (SEG_SLOTS'(1) << item_s1.seg_index);
		idx_p1           = SEEN_W'(item_s1.seg_index) + SEEN_W'(1);
		seen_nxt         = (idx_p1 > seen_q) ? idx_p1 : seen_q;
		final_index_nxt  = final_index_q;
		final_bytes_nxt  = final_bytes_q;
		final_known_nxt  = final_known_q;
		common_bytes_nxt = common_bytes_q;
		common_known_nxt = common_known_q;
		if (item_s1.is_last) begin
			if (!final_known_q) begin
				final_known_nxt = 1'b1;
				final_index_nxt = item_s1.seg_index;
				final_bytes_nxt = item_s1.seg_bytes;
				if (item_s1.seg_index == '0) begin
					common_bytes_nxt = item_s1.seg_bytes;
					common_known_nxt = 1'b1;
				end
			end
		end else begin
			common_bytes_nxt = item_s1.seg_bytes;
			common_known_nxt = 1'b1;
		end
		if (item_s1.clear) begin
			map_nxt          = '0;
			seen_nxt         = '0;
			final_index_nxt  = '0;
			final_bytes_nxt  = '0;
			final_known_nxt  = 1'b0;
			common_bytes_nxt = '0;
			common_known_nxt = 1'b0;
		end
	end

	srt_gap_check u_gap (
		.map     (map_nxt),
		.seen    (seen_nxt),
		.no_gaps (no_gaps)
	);

	always_comb begin
		if (item_s1.clear) begin
			done_nxt = 1'b0;
		end else begin
			done_nxt = done_q || (final_known_nxt && no_gaps);
		end
		common_eff = common_known_nxt ? common_bytes_nxt : '0;
		total      = TOTAL_W'(common_eff) * TOTAL_W'(final_index_nxt)
			+ TOTAL_W'(final_bytes_nxt);
		if (!done_nxt) begin
			total = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q          <= '0;
			seen_q         <= '0;
			final_index_q  <= '0;
			final_bytes_q  <= '0;
			final_known_q  <= 1'b0;
			common_bytes_q <= '0;
			common_known_q <= 1'b0;
			done_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				map_q          <= map_nxt;
				seen_q         <= seen_nxt;
				final_index_q  <= final_index_nxt;
				final_bytes_q  <= final_bytes_nxt;
				final_known_q  <= final_known_nxt;
				common_bytes_q <= common_bytes_nxt;
				common_known_q <= common_known_nxt;
				done_q         <= done_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.complete    <= done_nxt;
			result_q.total_bytes <= total;
			result_q.last_seen   <= final_known_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[design/srt_checker.sv]
// Port checker for the segment reassembly tracker, bound to the top level.
module srt_checker import srt_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_valid,
	input result_t result
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 result_valid)
		else $error("Accepted word produced no result two cycles later.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, 2))
		else $error("Result strobe without an accepted word.");

	a_total_needs_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.total_bytes != '0)) |-> result.complete)
		else $error("Nonzero total reported while not complete.");

	a_complete_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.complete) |-> result.last_seen)
		else $error("Complete reported before the last segment was seen.");

endmodule

bind segment_reassembly_tracker srt_checker u_srt_checker (.*);

[dv/segment_reassembly_tracker_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the segment reassembly tracker with a predicting scoreboard.
module segment_reassembly_tracker_tb import srt_pkg::*;;

	class reassembly_checker;
		logic [SEG_SLOTS-1:0]    present_map;
		logic [SEEN_W-1:0]       seen_count;
		logic [SEG_INDEX_W-1:0]  final_index;
		logic [SEG_BYTES_W-1:0]  final_bytes;
		logic [SEG_BYTES_W-1:0]  common_bytes;
		logic                    final_known;
		logic                    common_known;
		logic                    done_flag;
		result_t                 pending_status[$];
		int                      mismatches;
		int                      checked;
		int                      objects_done;
		int                      clears;

		function new();
			mismatches   = 0;
			checked      = 0;
			objects_done = 0;
			clears       = 0;
			clear_object();
		endfunction

		function void clear_object();
			present_map  = '0;
			seen_count   = '0;
			final_index  = '0;
			final_bytes  = '0;
			common_bytes = '0;
			final_known  = 1'b0;
			common_known = 1'b0;
			done_flag    = 1'b0;
		endfunction

		function bit gap_free();
			int i;
			if (seen_count == 0)
				return 1'b0;
			for (i = 0; i < int'(seen_count); i++)
				if (!present_map[i])
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_word(item_t w);
			result_t     status;
			logic [31:0] size_sum;
			if (w.clear) begin
				clear_object();
				clears++;
			end else begin
				present_map[w.seg_index] = 1'b1;
				if ({1'b0, w.seg_index} + 7'd1 > seen_count)
					seen_count = {1'b0, w.seg_index} + 7'd1;
				if (w.is_last) begin
					if (!final_known) begin
						final_known = 1'b1;
						final_index = w.seg_index;
						final_bytes = w.seg_bytes;
						if (w.seg_index == 0) begin
							common_bytes = w.seg_bytes;
							common_known = 1'b1;
						end
					end
				end else begin
					common_bytes = w.seg_bytes;
					common_known = 1'b1;
				end
				if (final_known && !done_flag && gap_free()) begin
					done_flag = 1'b1;
					objects_done++;
				end
			end
			status.complete    = done_flag;
			status.last_seen   = final_known;
			status.total_bytes = '0;
			if (done_flag) begin
				size_sum = (common_known ? 32'(common_bytes) : 32'd0) * 32'(final_index)
					+ 32'(final_bytes);
				status.total_bytes = size_sum[TOTAL_W-1:0];
			end
			pending_status.push_back(status);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 25)
				$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_word(result_t got);
			result_t want;
			if (pending_status.size() == 0) begin
				report_mismatch("result strobe with no word outstanding");
				return;
			end
			want = pending_status.pop_front();
			checked++;
			if (got.complete !== want.complete)
				report_mismatch($sformatf("complete got %b want %b", got.complete,
					want.complete));
			if (got.total_bytes !== want.total_bytes)
				report_mismatch($sformatf("total_bytes got %0d want %0d", got.total_bytes,
					want.total_bytes));
			if (got.last_seen !== want.last_seen)
				report_mismatch($sformatf("last_seen got %b want %b", got.last_seen,
					want.last_seen));
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    result_valid;
	result_t result;

	reassembly_checker sb;
	int                words_sent;
	bit                gaps_on;

	segment_reassembly_tracker u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d results outstanding.", sb.pending_status.size());
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_word(result);
			if (start && !busy)
				sb.note_word(item);
		end
	end

	task automatic send_word(input item_t w);
		@(negedge clk);
		item  <= w;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		words_sent++;
	endtask

	task automatic maybe_idle();
		logic [31:0] noise;
		while (gaps_on && $urandom_range(99) < 38) begin
			noise = $urandom;
			@(negedge clk);
			start <= 1'b0;
			item  <= noise[$bits(item_t)-1:0];
		end
	endtask

	task automatic send_seg(input int idx, input int nbytes, input bit last);
		item_t w;
		w.clear     = 1'b0;
		w.seg_index = idx[SEG_INDEX_W-1:0];
		w.seg_bytes = nbytes[SEG_BYTES_W-1:0];
		w.is_last   = last;
		send_word(w);
		maybe_idle();
	endtask

	task automatic send_clear();
		logic [31:0] noise;
		item_t       w;
		noise = $urandom;
		w       = noise[$bits(item_t)-1:0];
		w.clear = 1'b1;
		send_word(w);
		maybe_idle();
	endtask

	function automatic int pick_bytes();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return 0;
		if (pick < 30)
			return (1 << SEG_BYTES_W) - 1;
		return $urandom_range((1 << SEG_BYTES_W) - 1);
	endfunction

	task automatic send_noise();
		logic [31:0] noise;
		item_t       w;
		noise   = $urandom;
		w       = noise[$bits(item_t)-1:0];
		w.clear = ($urandom_range(19) == 0);
		send_word(w);
		maybe_idle();
	endtask

	task automatic run_object();
		int order[SEG_SLOTS];
		int n, k, j, tmp, dropped, pick, common, tail, idx;
		pick = $urandom_range(99);
		if (pick < 65)
			n = $urandom_range(8, 1);
		else if (pick < 90)
			n = $urandom_range(32, 9);
		else
			n = $urandom_range(SEG_SLOTS, 33);
		common  = pick_bytes();
		tail    = pick_bytes();
		dropped = ($urandom_range(9) == 0) ? $urandom_range(n - 1) : -1;
		for (k = 0; k < n; k++)
			order[k] = k;
		for (k = n - 1; k > 0; k--) begin
			j        = $urandom_range(k);
			tmp      = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		send_clear();
		for (k = 0; k < n; k++) begin
			idx = order[k];
			if (idx != dropped) begin
				if ($urandom_range(19) == 0)
					send_seg(idx, pick_bytes(), $urandom_range(1));
				else
					send_seg(idx, (idx == n - 1) ? tail : common, idx == n - 1);
			end
			if ($urandom_range(99) < 8) begin
				if ($urandom_range(1))
					send_seg(order[$urandom_range(k)], pick_bytes(), $urandom_range(1));
				else
					send_noise();
			end
		end
	endtask

	initial begin
		int k;
		sb         = new();
		words_sent = 0;
		gaps_on    = 1'b1;
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A lone final segment at index zero, then a later final segment and size updates.
		send_seg(0, 0, 1'b1);
		send_seg(0, 8191, 1'b1);
		send_seg(0, 5, 1'b0);
		send_seg(63, 8191, 1'b0);
		send_clear();
		// Complete without any common size: only final-marked segments arrive.
		send_seg(1, 7, 1'b1);
		send_seg(0, 8191, 1'b1);
		send_clear();
		// Out of order with a gap that is filled last.
		send_seg(3, 8191, 1'b0);
		send_seg(1, 8191, 1'b1);
		send_seg(0, 1000, 1'b0);
		send_seg(2, 8191, 1'b0);
		send_seg(2, 0, 1'b0);
		send_clear();
		// Final segment at the top index with large sizes.
		send_seg(63, 8191, 1'b1);
		send_seg(62, 8191, 1'b0);
		send_seg(0, 8191, 1'b0);
		send_clear();
		send_seg(0, 4096, 1'b0);
		send_seg(1, 1, 1'b1);

		while (words_sent < 1330) begin
			gaps_on = !(words_sent > 500 && words_sent < 800);
			if ($urandom_range(9) == 0)
				send_noise();
			else
				run_object();
		end
		gaps_on = 1'b1;

		@(negedge clk);
		start <= 1'b0;
		for (k = 0; k < 200 && sb.pending_status.size() > 0; k++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (sb.pending_status.size() > 0) begin
			void'(sb.pending_status.pop_front());
			sb.report_mismatch("expected result never arrived");
		end

		$display("Sent %0d words including %0d object clears; %0d results checked.",
			words_sent, sb.clears, sb.checked);
		$display("Objects seen to complete: %0d; mismatches: %0d.", sb.objects_done,
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[segment_reassembly_tracker.f]
design/srt_pkg.sv
design/srt_gap_check.sv
design/segment_reassembly_tracker.sv
design/srt_checker.sv
dv/segment_reassembly_tracker_tb.sv
